// ===== src/rlh_pkg.sv =====
// Shared types, constants and arithmetic helpers for the RGB and luma histogram unit.
// Depends on nothing. Used by rgb_luma_histogram_unit.
package rlh_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int BIN_WIDTH   = 8;
	localparam int NUM_BINS    = 1 << BIN_WIDTH;

	localparam int NUM_HIST  = 4;
	localparam int HIST_RED  = 0;
	localparam int HIST_GRN  = 1;
	localparam int HIST_BLU  = 2;
	localparam int HIST_LUMA = 3;

	localparam logic [1:0] MODE_ACC   = 2'd0;
	localparam logic [1:0] MODE_RD    = 2'd1;
	localparam logic [1:0] MODE_RDCLR = 2'd2;

	// Weighted sum 299R + 587G + 114B + 500 peaks at 255500, which fits in 18 bits.
	localparam int LSUM_WIDTH = 18;
	// floor(x / 1000) == (x * 268436) >> 28 for every x below 2^18.
	localparam int LUMA_RECIP_WIDTH = 19;
	localparam int LUMA_RECIP       = 268436;
	localparam int LUMA_SHIFT       = 28;
	localparam int LUMA_PROD_WIDTH  = LSUM_WIDTH + LUMA_RECIP_WIDTH;

	// Result queue; the depth must be a power of two so the pointers wrap.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = OQ_AW + 1;
	localparam int CRED_W   = OQ_AW + 2;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [OUT_WIDTH-1:0]   out_count_t;
	typedef logic [BIN_WIDTH-1:0]   bin_t;
	typedef logic [LSUM_WIDTH-1:0]  lsum_t;

	typedef struct packed {
		out_count_t red;
		out_count_t green;
		out_count_t blue;
		out_count_t luma;
	} result_t;

	function automatic lsum_t luma_sum(input bin_t r, input bin_t g, input bin_t b);
		return LSUM_WIDTH'(r) * LSUM_WIDTH'(299) + LSUM_WIDTH'(g) * LSUM_WIDTH'(587)
			+ LSUM_WIDTH'(b) * LSUM_WIDTH'(114) + LSUM_WIDTH'(500);
	endfunction

	// Exact division by 1000 through a reciprocal multiply.
	function automatic bin_t luma_bin(input lsum_t s);
		logic [LUMA_PROD_WIDTH-1:0] p;
		p = LUMA_PROD_WIDTH'(s) * LUMA_PROD_WIDTH'(LUMA_RECIP);
		return p[LUMA_SHIFT +: BIN_WIDTH];
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (&v) ? v : v + count_t'(1);
	endfunction

	function automatic out_count_t clamp_out(input count_t v);
		if ((COUNT_WIDTH > OUT_WIDTH) && ((v >> OUT_WIDTH) != '0)) begin
			return '1;
		end
		return OUT_WIDTH'(v);
	endfunction

endpackage

// ===== src/rgb_luma_histogram_unit.sv =====
// Path: a read transaction's result is offered after passing stage 1, stage 2 and the queue.
// Throughput: one transaction per cycle while in_stall is low, limited by one read and one
// write port per histogram RAM; a four-entry result queue lets reads flow on while the output
// side stalls briefly. Reset: arst_n clears control state; a clearing pass then zeroes all
// four histograms, one bin per cycle, with in_stall held high until it is done.
module rgb_luma_histogram_unit
	import rlh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       mode,
	input  logic [7:0]       blue,
	input  logic [7:0]       green,
	input  logic [7:0]       red,
	input  logic [7:0]       bin,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      red_count,
	output logic [31:0]      green_count,
	output logic [31:0]      blue_count,
	output logic [31:0]      luma_count
);

	// Pipeline overview.
	// Stage 1 holds the accepted transaction and its weighted luma sum. The luma bin is
	// derived from the sum here and all four RAM reads are issued at the end of the stage.
	// Stage 2 receives the read data, applies forwarding from the registered copy of the previous
	// write, writes back the incremented (or cleared) counts and pushes read results
	// into the result queue.

	logic in_acc;
	logic clearing;
	logic [BIN_WIDTH:0] clr_q;

	// Stage 1 registers.
	logic       valid_s1;
	logic [1:0] mode_s1;
	bin_t       red_s1, green_s1, blue_s1, bin_s1;
	lsum_t      lsum_s1;
	bin_t       luma_s1;
	bin_t       raddr [NUM_HIST];

	// Stage 2 registers.
	logic       valid_s2;
	logic [1:0] mode_s2;
	bin_t       addr_s2 [NUM_HIST];

	// RAM ports and forwarding copy of the last write.
	logic [NUM_HIST-1:0] ram_we;
	bin_t                ram_waddr [NUM_HIST];
	count_t              ram_wdata [NUM_HIST];
	count_t              ram_rdata [NUM_HIST];
	count_t              cur       [NUM_HIST];
	logic [NUM_HIST-1:0] wr_en_q;
	bin_t                wr_addr_q [NUM_HIST];
	count_t              wr_data_q [NUM_HIST];

	// Result queue.
	result_t          oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wptr_q, rptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             push, pop;
	logic             rd_s1, rd_s2;
	logic [CRED_W-1:0] credit;
	result_t          head;

	// Flow control. Every read transaction in flight holds a reserved queue slot, so a result
	// never finds the queue full. The stall does not look at the output side's pop, which
	// keeps it free of a combinational path from out_stall.
	assign rd_s1  = valid_s1 && (mode_s1 != MODE_ACC);
	assign rd_s2  = valid_s2 && (mode_s2 != MODE_ACC);
	assign credit = CRED_W'(cnt_q) + CRED_W'(rd_s1) + CRED_W'(rd_s2);

	assign clearing = !clr_q[BIN_WIDTH];
	assign in_stall = clearing || (credit >= CRED_W'(OQ_DEPTH));
	assign in_acc   = in_valid && !in_stall;

	// Clearing pass after reset: one bin of every histogram per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + (BIN_WIDTH + 1)'(1);
		end
	end

	// Stage 1. The unused mode code is accepted and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc && (mode == MODE_ACC || mode == MODE_RD || mode == MODE_RDCLR);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1  <= mode;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			bin_s1   <= bin;
			lsum_s1  <= luma_sum(red, green, blue);
		end
	end

	assign luma_s1 = luma_bin(lsum_s1);

	// An accumulate reads each histogram at its own channel value; a read mode reads all
	// four at the requested bin.
	always_comb begin
		if (mode_s1 == MODE_ACC) begin
			raddr[HIST_RED]  = red_s1;
			raddr[HIST_GRN]  = green_s1;
			raddr[HIST_BLU]  = blue_s1;
			raddr[HIST_LUMA] = luma_s1;
		end else begin
			for (int c = 0; c < NUM_HIST; c++) begin
				raddr[c] = bin_s1;
			end
		end
	end

	// Stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		addr_s2 <= raddr;
	end

	// The RAM read issued on the same edge as the previous write returns the old count,
	// so the registered copy of that write takes its place when the addresses match.
	always_comb begin
		for (int c = 0; c < NUM_HIST; c++) begin
			if (wr_en_q[c] && (wr_addr_q[c] == addr_s2[c])) begin
				cur[c] = wr_data_q[c];
			end else begin
				cur[c] = ram_rdata[c];
			end
		end
	end

	// Write-back, with the clearing pass taking the write ports while it runs.
	always_comb begin
		for (int c = 0; c < NUM_HIST; c++) begin
			ram_we[c]    = 1'b0;
			ram_waddr[c] = addr_s2[c];
			ram_wdata[c] = '0;
			if (clearing) begin
				ram_we[c]    = 1'b1;
				ram_waddr[c] = clr_q[BIN_WIDTH-1:0];
			end else if (valid_s2) begin
				unique case (mode_s2)
					MODE_ACC: begin
						ram_we[c]    = 1'b1;
						ram_wdata[c] = sat_inc(cur[c]);
					end
					MODE_RDCLR: begin
						ram_we[c] = 1'b1;
					end
					default: begin
						ram_we[c] = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= '0;
		end else begin
			wr_en_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= ram_waddr;
		wr_data_q <= ram_wdata;
	end

	for (genvar gi = 0; gi < NUM_HIST; gi++) begin : g_hist
		rlh_ram #(
			.WIDTH(COUNT_WIDTH),
			.DEPTH(NUM_BINS)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[gi]),
			.waddr(ram_waddr[gi]),
			.wdata(ram_wdata[gi]),
			.raddr(raddr[gi]),
			.rdata(ram_rdata[gi])
		);
	end

	// Result queue. A read transaction pushes the counts it saw before any clear.
	assign push = rd_s2;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + OQ_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + OQ_AW'(1);
			end
			cnt_q <= cnt_q + OQ_CW'(push) - OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_q[wptr_q] <= '{
				red:   clamp_out(cur[HIST_RED]),
				green: clamp_out(cur[HIST_GRN]),
				blue:  clamp_out(cur[HIST_BLU]),
				luma:  clamp_out(cur[HIST_LUMA])
			};
		end
	end

	assign head        = oq_q[rptr_q];
	assign out_valid   = (cnt_q != '0);
	assign red_count   = head.red;
	assign green_count = head.green;
	assign blue_count  = head.blue;
	assign luma_count  = head.luma;

	// The reservation scheme must keep queued plus in-flight results within the queue.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit <= CRED_W'(OQ_DEPTH))
		else $error("result queue reservation exceeded");

	// Once the clearing pass ends it never restarts without a reset.
	a_clear_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing |=> !clearing)
		else $error("clearing pass restarted");

	// Nothing may be in the pipeline while the clearing pass owns the write ports.
	a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!valid_s1 && !valid_s2))
		else $error("transaction in flight during clearing pass");

	// An accumulate in stage 2 updates all four histograms.
	a_acc_writes_all: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (mode_s2 == MODE_ACC) && !clearing) |-> (&ram_we))
		else $error("accumulate missed a histogram write");

	// A push without a pop grows the queue by exactly one entry.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + OQ_CW'(1)))
		else $error("result queue count out of step");

endmodule

// ===== src/rlh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written in the same cycle returns the old data.
// Depends on nothing.
module rlh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
